/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmse_pkg.sv */
// ----------------------------------------------------------------------------
// pmse_pkg
// Types and constants of the power monitor scaler and energy accumulator.
// ----------------------------------------------------------------------------
package pmse_pkg;

    // Field widths
    localparam int CH_W      = 2;
    localparam int VBUS_W    = 16;
    localparam int VSENSE_W  = 16;
    localparam int COUNT_W   = 24;
    localparam int ACC_W     = 48;
    localparam int VOLT_W    = 15;
    localparam int CURR_W    = 13;
    localparam int POWER_W   = 32;
    localparam int ENERGY_W  = 64;

    // Scale factors
    localparam int VOLT_MUL  = 125;   // mV = raw * 125 / 256
    localparam int VOLT_SHR  = 8;
    localparam int CURR_MUL  = 625;   // mA = |raw| * 625 / 4096
    localparam int CURR_SHR  = 12;
    localparam int POWER_MUL = 625;   // mW = |acc| * 625 / (2^19 * count)
    localparam int POWER_SHR = 19;

    // Numerator product width and the dividend after the 2^19 prescale
    localparam int NUM_W      = ACC_W + 10;
    localparam int DIVIDEND_W = NUM_W - POWER_SHR;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // Divide by five as multiply by ceil(2^34 / 5), exact over 32 bits
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
    localparam int          RECIP5_SHR = 34;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/pmse_div.sv */
// ----------------------------------------------------------------------------
// pmse_div
// Bit-serial restoring divider: one quotient bit per cycle, 39-bit dividend
// over a 24-bit divisor. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module pmse_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [pmse_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [pmse_pkg::COUNT_W-1:0]         divisor,
    output pmse_pkg::div_stat_t                  stat,
    output logic [pmse_pkg::DIVIDEND_W-1:0]      quotient
);
    import pmse_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [COUNT_W:0]      trial;
    logic [COUNT_W:0]      diff;
    logic                  ge;
    logic [COUNT_W-1:0]    rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // One restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* rtl/pmse_energy.sv */
// ----------------------------------------------------------------------------
// pmse_energy
// Per-channel 64-bit energy sums, cleared at reset, wrapping on overflow.
// ----------------------------------------------------------------------------
module pmse_energy #(
    parameter int CHANNELS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [pmse_pkg::CH_W-1:0]         ch,
    input  logic [pmse_pkg::ENERGY_W-1:0]     inc,
    output logic [pmse_pkg::ENERGY_W-1:0]     sum
);
    import pmse_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [ENERGY_W-1:0] total_reg [CHANNELS];
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    logic [ENERGY_W-1:0] sum_next;

    // Channels past the configured count read as zero and are never written
    assign idx      = IDX_W'(ch);
    assign in_range = (5'(ch) < 5'(CHANNELS));
    assign sum_next = total_reg[idx] + inc;
    assign sum      = in_range ? sum_next : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                total_reg[i] <= '0;
            end
        end else if (wr_en && in_range) begin
            total_reg[idx] <= sum_next;
        end
    end

endmodule

/* rtl/power_monitor_scaler_energy_accumulator.sv */
// ----------------------------------------------------------------------------
// power_monitor_scaler_energy_accumulator
// Converts one channel's raw monitor readings to mV, mA and mW, and keeps a
// running per-channel energy sum.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. After the input beat is accepted, the
// magnitude and scale products are registered, the bit-serial power divider is
// loaded and runs over the 39-bit dividend (one quotient bit per cycle), the
// sequencer sees the divider finish, saturation and the divide by five are
// registered, and then the energy update and the result load happen together.
// s_ready is high only while no beat is in work, so a new beat is not taken
// until the previous one has reached the result register; a beat that
// reaches the output while the previous result still waits on m_ready stalls
// for as long as that wait lasts. The next beat may be taken while the previous
// result still waits on m_ready. A zero sample count reports zero power with
// the fault flag and leaves the energy sum alone; channels at or above
// CHANNELS report zero energy and touch no sum.
// ----------------------------------------------------------------------------
module power_monitor_scaler_energy_accumulator #(
    parameter int CHANNELS = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pmse_pkg::CH_W-1:0]             s_channel,
    input  logic [pmse_pkg::VBUS_W-1:0]           s_bus_voltage_raw,
    input  logic signed [pmse_pkg::VSENSE_W-1:0]  s_sense_voltage_raw,
    input  logic [pmse_pkg::COUNT_W-1:0]          s_sample_count,
    input  logic signed [pmse_pkg::ACC_W-1:0]     s_power_accumulator,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pmse_pkg::CH_W-1:0]             m_channel_out,
    output logic [pmse_pkg::VOLT_W-1:0]           m_voltage_mv,
    output logic [pmse_pkg::CURR_W-1:0]           m_current_ma,
    output logic [pmse_pkg::POWER_W-1:0]          m_power_mw,
    output logic [pmse_pkg::ENERGY_W-1:0]         m_energy_mws,
    output logic                                  m_zero_count_fault
);
    import pmse_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Captured beat
    logic [CH_W-1:0]       ch_reg;
    logic [VBUS_W-1:0]     vbus_reg;
    logic [VSENSE_W-1:0]   vsense_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [ACC_W-1:0]      acc_reg;

    // Work registers
    logic [VOLT_W-1:0]     volt_reg;
    logic [CURR_W-1:0]     curr_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic                  fault_reg;
    logic [POWER_W-1:0]    power_reg;
    logic [ENERGY_W-1:0]   inc_reg;
    logic                  div_start_reg;

    // Result registers
    logic                  m_valid_reg;
    logic [CH_W-1:0]       m_ch_reg;
    logic [VOLT_W-1:0]     m_volt_reg;
    logic [CURR_W-1:0]     m_curr_reg;
    logic [POWER_W-1:0]    m_power_reg;
    logic [ENERGY_W-1:0]   m_energy_reg;
    logic                  m_fault_reg;

    // Combinational next values
    logic [ACC_W-1:0]      acc_mag;
    logic [NUM_W-1:0]      num_next;
    logic [VSENSE_W:0]     smag;
    logic [VBUS_W+6:0]     volt_prod;
    logic [VSENSE_W+10:0]  curr_prod;
    logic [POWER_W-1:0]    power_next;
    logic [63:0]           recip_prod;
    logic [ENERGY_W-1:0]   inc_next;
    logic                  out_free;

    div_stat_t             div_stat;
    logic [DIVIDEND_W-1:0] quotient;
    logic [ENERGY_W-1:0]   energy_sum;

    // Magnitudes and constant-scale products
    always_comb begin
        acc_mag   = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        num_next  = NUM_W'(acc_mag) * NUM_W'(POWER_MUL);
        smag      = vsense_reg[VSENSE_W-1] ? ((VSENSE_W+1)'(17'h10000)
                    - {1'b0, vsense_reg}) : {1'b0, vsense_reg};
        volt_prod = (VBUS_W+7)'(vbus_reg) * (VBUS_W+7)'(VOLT_MUL);
        curr_prod = (VSENSE_W+11)'(smag) * (VSENSE_W+11)'(CURR_MUL);
    end

    // Saturate the quotient, then divide by five through the reciprocal
    always_comb begin
        if (fault_reg) begin
            power_next = '0;
        end else if (|quotient[DIVIDEND_W-1:POWER_W]) begin
            power_next = '1;
        end else begin
            power_next = quotient[POWER_W-1:0];
        end
        recip_prod = 64'(power_next) * 64'(RECIP5);
        inc_next   = ENERGY_W'(recip_prod[63:RECIP5_SHR]);
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer, work registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            // Divider starts in the cycle after the products are registered
            div_start_reg <= (state_reg == ST_MUL);
            // Taken result drops unless a new one loads in ST_OUT
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ch_reg     <= s_channel;
                        vbus_reg   <= s_bus_voltage_raw;
                        vsense_reg <= s_sense_voltage_raw;
                        count_reg  <= s_sample_count;
                        acc_reg    <= s_power_accumulator;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    volt_reg      <= volt_prod[VOLT_SHR+VOLT_W-1:VOLT_SHR];
                    curr_reg      <= curr_prod[CURR_SHR+CURR_W-1:CURR_SHR];
                    dividend_reg  <= num_next[NUM_W-1:POWER_SHR];
                    fault_reg     <= (count_reg == '0);
                    state_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    power_reg <= power_next;
                    inc_reg   <= inc_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_ch_reg     <= ch_reg;
                        m_volt_reg   <= volt_reg;
                        m_curr_reg   <= curr_reg;
                        m_power_reg  <= power_reg;
                        m_energy_reg <= energy_sum;
                        m_fault_reg  <= fault_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    pmse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    pmse_energy #(
        .CHANNELS (CHANNELS)
    ) u_energy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (state_reg == ST_OUT && out_free),
        .ch      (ch_reg),
        .inc     (inc_reg),
        .sum     (energy_sum)
    );

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_channel_out      = m_ch_reg;
    assign m_voltage_mv       = m_volt_reg;
    assign m_current_ma       = m_curr_reg;
    assign m_power_mw         = m_power_reg;
    assign m_energy_mws       = m_energy_reg;
    assign m_zero_count_fault = m_fault_reg;

endmodule

/* rtl/pmse_checker.sv */
// ----------------------------------------------------------------------------
// pmse_checker
// Port-level checks on the scaler and energy accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmse_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [pmse_pkg::CH_W-1:0]             s_channel,
    input  logic [pmse_pkg::VBUS_W-1:0]           s_bus_voltage_raw,
    input  logic signed [pmse_pkg::VSENSE_W-1:0]  s_sense_voltage_raw,
    input  logic [pmse_pkg::COUNT_W-1:0]          s_sample_count,
    input  logic signed [pmse_pkg::ACC_W-1:0]     s_power_accumulator,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [pmse_pkg::CH_W-1:0]             m_channel_out,
    input  logic [pmse_pkg::VOLT_W-1:0]           m_voltage_mv,
    input  logic [pmse_pkg::CURR_W-1:0]           m_current_ma,
    input  logic [pmse_pkg::POWER_W-1:0]          m_power_mw,
    input  logic [pmse_pkg::ENERGY_W-1:0]         m_energy_mws,
    input  logic                                  m_zero_count_fault
);

    // A stalled result beat stays up
    `AST_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result beat dropped")

    // A stalled result keeps its power and energy
    `AST_NEXT(a_m_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_power_mw) && $stable(m_energy_mws), "stalled result changed")

    // One beat in work at a time
    `AST_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken while busy")

    // Zero sample count forces zero power
    `AST_IMPL(a_fault_zero, aclk, aresetn, m_valid && m_zero_count_fault, m_power_mw == '0, "fault with nonzero power")

    // Scaled values stay in their ranges
    `AST_IMPL(a_range, aclk, aresetn, m_valid, (m_voltage_mv <= 15'd31999) && (m_current_ma <= 13'd5000), "scaled value out of range")

endmodule

bind power_monitor_scaler_energy_accumulator pmse_checker u_pmse_checker (.*);
